FILE: design/mfde_pkg.sv
package mfde_pkg;

    localparam int DEF_FRAME_WIDTH  = 128;
    localparam int DEF_FRAME_HEIGHT = 64;
    localparam int DEF_ROW_BYTES    = 16;
    localparam int COORD_W          = 12;
    localparam int EXT_W            = 14;

    typedef enum logic [2:0] {
        MODE_CLEAR  = 3'd0,
        MODE_SET    = 3'd1,
        MODE_READ   = 3'd2,
        MODE_LINE   = 3'd3,
        MODE_RECT   = 3'd4,
        MODE_FILL   = 3'd5,
        MODE_INVERT = 3'd6,
        MODE_NONE   = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        SWEEP_FILL0 = 2'd0,
        SWEEP_FILL1 = 2'd1,
        SWEEP_INV   = 2'd2
    } sweep_t;

    typedef struct packed {
        logic                      sweep_start;
        sweep_t                    sweep_op;
        logic                      line_start;
        logic signed [EXT_W-1:0]   lx0;
        logic signed [EXT_W-1:0]   ly0;
        logic signed [EXT_W-1:0]   lx1;
        logic signed [EXT_W-1:0]   ly1;
        logic                      pix_start;
        logic                      pix_read;
        logic                      fill_start;
        logic                      on;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic rd_bit;
    } dp_status_t;

endpackage

FILE: design/mfde_datapath.sv
module mfde_datapath #(
    parameter int FRAME_WIDTH  = mfde_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = mfde_pkg::DEF_FRAME_HEIGHT,
    parameter int ROW_BYTES    = mfde_pkg::DEF_ROW_BYTES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mfde_pkg::dp_cmd_t    cmd,
    output mfde_pkg::dp_status_t status
);
    import mfde_pkg::*;

    localparam int DEPTH = ROW_BYTES * FRAME_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int EW    = EXT_W + 2;

    typedef enum logic [7:0] {
        D_IDLE  = 8'b0000_0001,
        D_INIT  = 8'b0000_0010,
        D_SWRD  = 8'b0000_0100,
        D_SWWR  = 8'b0000_1000,
        D_PLOT  = 8'b0001_0000,
        D_PRD   = 8'b0010_0000,
        D_PWR   = 8'b0100_0000,
        D_DONE  = 8'b1000_0000
    } dstate_t;

    logic [7:0] mem [DEPTH];

    dstate_t              st_reg, st_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    sweep_t               op_reg, op_next;
    logic                 line_reg, line_next;
    logic                 fillm_reg, fillm_next;
    logic                 rdm_reg, rdm_next;
    logic                 on_reg, on_next;
    logic signed [EXT_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [EXT_W-1:0] x1_reg, x1_next, y1_reg, y1_next;
    logic signed [EXT_W-1:0] xs_reg, xs_next;
    logic signed [EW-1:0] dx_reg, dx_next, dy_reg, dy_next, err_reg, err_next;
    logic                 sy_reg, sy_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [2:0]           bit_reg, bit_next;
    logic                 rdbit_reg, rdbit_next;
    logic [7:0]           rdata_reg;
    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic [7:0]           wdata;
    logic                 inb;
    logic [AW-1:0]        paddr;
    logic [7:0]           pmask;
    logic signed [EW-1:0] e2;
    logic                 at_end;

    always_comb begin
        inb   = (x_reg >= 0) && (y_reg >= 0) && (x_reg < EXT_W'(FRAME_WIDTH))
                && (y_reg < EXT_W'(FRAME_HEIGHT));
        paddr = AW'(y_reg[EXT_W-2:0] * ROW_BYTES + (x_reg[EXT_W-2:0] >> 3));
        pmask = 8'h80 >> x_reg[2:0];
        e2    = err_reg <<< 1;
        at_end = (x_reg == x1_reg) && (y_reg == y1_reg);
    end

    always_comb begin
        st_next = st_reg; cnt_next = cnt_reg; op_next = op_reg;
        line_next = line_reg; fillm_next = fillm_reg; rdm_next = rdm_reg;
        on_next = on_reg; x_next = x_reg; y_next = y_reg;
        x1_next = x1_reg; y1_next = y1_reg; xs_next = xs_reg;
        dx_next = dx_reg; dy_next = dy_reg; err_next = err_reg; sy_next = sy_reg;
        addr_next = addr_reg; bit_next = bit_reg; rdbit_next = rdbit_reg;
        we = 1'b0; waddr = '0; wdata = '0; raddr = cnt_reg[AW-1:0];
        case (st_reg)
            D_INIT: begin
                we = 1'b1; waddr = cnt_reg[AW-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(DEPTH - 1)) st_next = D_IDLE;
            end
            D_IDLE: begin
                on_next = cmd.on;
                if (cmd.sweep_start) begin
                    op_next = cmd.sweep_op; cnt_next = '0; st_next = D_SWRD;
                end else if (cmd.line_start || cmd.fill_start || cmd.pix_start) begin
                    line_next = cmd.line_start; fillm_next = cmd.fill_start;
                    rdm_next = cmd.pix_read; rdbit_next = 1'b0;
                    x_next = cmd.lx0; y_next = cmd.ly0; xs_next = cmd.lx0;
                    x1_next = cmd.lx1; y1_next = cmd.ly1;
                    dx_next = EW'(cmd.lx1) - EW'(cmd.lx0);
                    dy_next = (cmd.ly1 >= cmd.ly0) ? EW'(cmd.ly0) - EW'(cmd.ly1)
                                                   : EW'(cmd.ly1) - EW'(cmd.ly0);
                    err_next = EW'(cmd.lx1) - EW'(cmd.lx0)
                             + ((cmd.ly1 >= cmd.ly0) ? EW'(cmd.ly0) - EW'(cmd.ly1)
                                                     : EW'(cmd.ly1) - EW'(cmd.ly0));
                    sy_next = cmd.ly0 < cmd.ly1;
                    st_next = (cmd.fill_start && (cmd.lx0 > cmd.lx1 || cmd.ly0 > cmd.ly1))
                              ? D_DONE : D_PLOT;
                end
            end
            D_SWRD: begin
                raddr = cnt_reg[AW-1:0]; st_next = D_SWWR;
            end
            D_SWWR: begin
                we = 1'b1; waddr = cnt_reg[AW-1:0];
                case (op_reg)
                    SWEEP_FILL1: wdata = 8'hFF;
                    SWEEP_INV:   wdata = ~rdata_reg;
                    default:     wdata = 8'h00;
                endcase
                cnt_next = cnt_reg + 1'b1;
                st_next = (cnt_reg == CW'(DEPTH - 1)) ? D_DONE : D_SWRD;
            end
            D_PLOT: begin
                addr_next = paddr; bit_next = x_reg[2:0]; raddr = paddr;
                st_next = D_PRD;
            end
            D_PRD: begin
                raddr = addr_reg;
                st_next = D_PWR;
            end
            D_PWR: begin
                if (inb) begin
                    if (rdm_reg) begin
                        rdbit_next = rdata_reg[3'd7 - bit_reg];
                    end else begin
                        we = 1'b1; waddr = addr_reg;
                        wdata = on_reg ? (rdata_reg | pmask) : (rdata_reg & ~pmask);
                    end
                end
                st_next = D_PLOT;
                if (line_reg) begin
                    if (at_end) st_next = D_DONE;
                    else begin
                        err_next = err_reg;
                        if (e2 >= dy_reg) begin
                            err_next = err_next + dy_reg;
                            x_next = x_reg + 1'b1;
                        end
                        if (e2 <= dx_reg) begin
                            err_next = err_next + dx_reg;
                            y_next = sy_reg ? y_reg + 1'b1 : y_reg - 1'b1;
                        end
                    end
                end else if (fillm_reg) begin
                    if (x_reg == x1_reg) begin
                        x_next = xs_reg;
                        if (y_reg == y1_reg) st_next = D_DONE;
                        else y_next = y_reg + 1'b1;
                    end else x_next = x_reg + 1'b1;
                end else st_next = D_DONE;
            end
            D_DONE: st_next = D_IDLE;
            default: st_next = D_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= D_INIT; cnt_reg <= '0;
        end else begin
            st_reg <= st_next; cnt_reg <= cnt_next;
        end
        op_reg <= op_next; line_reg <= line_next; fillm_reg <= fillm_next;
        rdm_reg <= rdm_next; on_reg <= on_next; x_reg <= x_next; y_reg <= y_next;
        x1_reg <= x1_next; y1_reg <= y1_next; xs_reg <= xs_next;
        dx_reg <= dx_next; dy_reg <= dy_next; err_reg <= err_next; sy_reg <= sy_next;
        addr_reg <= addr_next; bit_reg <= bit_next; rdbit_reg <= rdbit_next;
    end

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign status.busy   = (st_reg != D_IDLE);
    assign status.done   = (st_reg == D_DONE);
    assign status.rd_bit = rdbit_reg;

`ifndef SYNTH
    a_done_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == D_DONE |-> $past(st_reg) != D_INIT)
        else $error("done without work");
    a_init_no_done: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == D_INIT |=> st_next != D_DONE || st_reg != D_INIT)
        else $error("init left for done");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("sweep counter out of range");
`endif
endmodule

FILE: design/mfde_ctrl.sv
module mfde_ctrl #(
    parameter int FRAME_WIDTH  = mfde_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = mfde_pkg::DEF_FRAME_HEIGHT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2:0]            mode,
    input  logic signed [11:0]    ax,
    input  logic signed [11:0]    ay,
    input  logic signed [11:0]    bx,
    input  logic signed [11:0]    by,
    input  logic                  on,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  m_bit,
    output mfde_pkg::dp_cmd_t     cmd,
    input  mfde_pkg::dp_status_t  status
);
    import mfde_pkg::*;

    typedef enum logic [4:0] {
        C_IDLE = 5'b00001,
        C_EDGE = 5'b00010,
        C_ISSU = 5'b00100,
        C_WAIT = 5'b01000,
        C_OUT  = 5'b10000
    } cstate_t;

    cstate_t st_reg, st_next;
    logic [2:0] mode_reg;
    logic [1:0] edge_reg, edge_next;
    logic signed [EXT_W-1:0] ax_reg, ay_reg, bx_reg, by_reg, r_e, b_e;
    logic on_reg, bit_reg, bit_next;
    logic signed [EXT_W-1:0] p0x, p0y, p1x, p1y;
    logic swap;

    assign s_tready = (st_reg == C_IDLE) && !status.busy && !m_tvalid;
    assign m_tvalid = (st_reg == C_OUT);
    assign m_bit    = bit_reg;

    always_comb begin
        r_e = ax_reg + bx_reg - 1'b1;
        b_e = ay_reg + by_reg - 1'b1;
        p0x = ax_reg; p0y = ay_reg; p1x = bx_reg; p1y = by_reg;
        if (mode_reg == MODE_RECT) begin
            case (edge_reg)
                2'd0: begin p1x = r_e; p1y = ay_reg; end
                2'd1: begin p0y = b_e; p1x = r_e; p1y = b_e; end
                2'd2: begin p1x = ax_reg; p1y = b_e; end
                default: begin p0x = r_e; p1x = r_e; p1y = b_e; end
            endcase
        end else if (mode_reg == MODE_FILL) begin
            p0x = (ax_reg < 0) ? '0 : ax_reg;
            p0y = (ay_reg < 0) ? '0 : ay_reg;
            p1x = (ax_reg + bx_reg > EXT_W'(FRAME_WIDTH)) ?
                  EXT_W'(FRAME_WIDTH - 1) : r_e;
            p1y = (ay_reg + by_reg > EXT_W'(FRAME_HEIGHT)) ?
                  EXT_W'(FRAME_HEIGHT - 1) : b_e;
        end
        swap = (p0x > p1x) || (p0x == p1x && p0y > p1y);
        cmd = '0;
        cmd.on = on_reg;
        cmd.sweep_op = (mode_reg == MODE_INVERT) ? SWEEP_INV :
                       (on_reg ? SWEEP_FILL1 : SWEEP_FILL0);
        cmd.lx0 = p0x; cmd.ly0 = p0y; cmd.lx1 = p1x; cmd.ly1 = p1y;
        if (mode_reg == MODE_LINE || mode_reg == MODE_RECT) begin
            if (swap) begin
                cmd.lx0 = p1x; cmd.ly0 = p1y; cmd.lx1 = p0x; cmd.ly1 = p0y;
            end
        end
        if (st_reg == C_ISSU) begin
            case (mode_reg)
                MODE_CLEAR, MODE_INVERT: cmd.sweep_start = 1'b1;
                MODE_SET:  cmd.pix_start = 1'b1;
                MODE_READ: begin cmd.pix_start = 1'b1; cmd.pix_read = 1'b1; end
                MODE_LINE, MODE_RECT: cmd.line_start = 1'b1;
                MODE_FILL: cmd.fill_start = 1'b1;
                default: ;
            endcase
        end
    end

    always_comb begin
        st_next = st_reg; edge_next = edge_reg; bit_next = bit_reg;
        case (st_reg)
            C_IDLE: if (s_tvalid && s_tready) begin
                edge_next = 2'd0; bit_next = 1'b0; st_next = C_EDGE;
            end
            C_EDGE: begin
                if (mode_reg == MODE_NONE) st_next = C_OUT;
                else if ((mode_reg == MODE_RECT || mode_reg == MODE_FILL)
                         && (bx_reg <= 0 || by_reg <= 0)) st_next = C_OUT;
                else st_next = C_ISSU;
            end
            C_ISSU: st_next = C_WAIT;
            C_WAIT: if (status.done) begin
                bit_next = (mode_reg == MODE_READ) && status.rd_bit;
                if (mode_reg == MODE_RECT && edge_reg != 2'd3) begin
                    edge_next = edge_reg + 1'b1; st_next = C_ISSU;
                end else st_next = C_OUT;
            end
            C_OUT: if (m_tready) st_next = C_IDLE;
            default: st_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= C_IDLE;
        else st_reg <= st_next;
        edge_reg <= edge_next; bit_reg <= bit_next;
        if (s_tvalid && s_tready) begin
            mode_reg <= mode; on_reg <= on;
            ax_reg <= EXT_W'(ax); ay_reg <= EXT_W'(ay);
            bx_reg <= EXT_W'(bx); by_reg <= EXT_W'(by);
        end
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        status.busy |-> !s_tready) else $error("accept while busy");
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid) else $error("result repeated");
    a_issue_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == C_ISSU |=> st_reg == C_WAIT) else $error("issue lost");
`endif
endmodule

FILE: design/mono_framebuffer_draw_engine.sv
// Operation: set/read touch one pixel; line and fill read and write the store pixel by pixel;
// outline four lines; clear/invert read then rewrite every store byte in turn.
// Throughput: one command at a time; next word accepted after the result is taken.
// Reset: synchronous active-low aresetn; afterwards all ROW_BYTES*FRAME_HEIGHT bytes
// of the store are cleared in turn, during which no word is accepted.
module mono_framebuffer_draw_engine #(
    parameter int FRAME_WIDTH  = mfde_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = mfde_pkg::DEF_FRAME_HEIGHT,
    parameter int ROW_BYTES    = mfde_pkg::DEF_ROW_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // mode[2:0] ax[14:3] ay[26:15] bx[38:27] by[50:39] on[51]
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [7:0]  m_tdata    // pixel_value[0]
);
    import mfde_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       bit_out;

    mfde_ctrl #(
        .FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)
    ) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .mode(s_tdata[2:0]), .ax(s_tdata[14:3]), .ay(s_tdata[26:15]),
        .bx(s_tdata[38:27]), .by(s_tdata[50:39]), .on(s_tdata[51]),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_bit(bit_out),
        .cmd(cmd), .status(status)
    );

    mfde_datapath #(
        .FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT), .ROW_BYTES(ROW_BYTES)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status)
    );

    assign m_tdata = {7'd0, bit_out};
endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mfde_pkg::*;

    localparam int FW = DEF_FRAME_WIDTH;
    localparam int FH = DEF_FRAME_HEIGHT;
    localparam int RB = DEF_ROW_BYTES;
    localparam int STORE_SIZE = RB * FH;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;

    logic [7:0] shadow_fb [STORE_SIZE];
    bit         pixel_q [$];
    int         snd_idle_pct;
    int         rcv_idle_pct;
    bit         failed;

    mono_framebuffer_draw_engine DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // pixel model of the frame store
    function automatic void plot(int x, int y, bit on);
        int idx;
        if (x < 0 || y < 0 || x >= FW || y >= FH) return;
        idx = y * RB + x / 8;
        if (on) shadow_fb[idx] = shadow_fb[idx] | (8'h80 >> (x % 8));
        else    shadow_fb[idx] = shadow_fb[idx] & ~(8'h80 >> (x % 8));
    endfunction

    function automatic bit probe(int x, int y);
        if (x < 0 || y < 0 || x >= FW || y >= FH) return 1'b0;
        return shadow_fb[y * RB + x / 8][7 - x % 8];
    endfunction

    function automatic void trace_line(int x0, int y0, int x1, int y1, bit on);
        int dx, dy, sx, sy, err, e2, t;
        if (x0 > x1 || (x0 == x1 && y0 > y1)) begin
            t = x0; x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
        end
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y0 - y1 : y1 - y0;
        sx = (x0 < x1) ? 1 : -1;
        sy = (y0 < y1) ? 1 : -1;
        err = dx + dy;
        forever begin
            plot(x0, y0, on);
            if (x0 == x1 && y0 == y1) break;
            e2 = 2 * err;
            if (e2 >= dy) begin
                err += dy;
                x0 += sx;
            end
            if (e2 <= dx) begin
                err += dx;
                y0 += sy;
            end
        end
    endfunction

    function automatic bit draw_cmd(mode_t mode, int ax, int ay, int bx, int by, bit on);
        int x1, y1;
        case (mode)
            MODE_CLEAR: begin
                foreach (shadow_fb[i]) shadow_fb[i] = on ? 8'hFF : 8'h00;
            end
            MODE_SET:  plot(ax, ay, on);
            MODE_READ: return probe(ax, ay);
            MODE_LINE: trace_line(ax, ay, bx, by, on);
            MODE_RECT: begin
                if (bx > 0 && by > 0) begin
                    x1 = ax + bx - 1;
                    y1 = ay + by - 1;
                    trace_line(ax, ay, x1, ay, on);
                    trace_line(ax, y1, x1, y1, on);
                    trace_line(ax, ay, ax, y1, on);
                    trace_line(x1, ay, x1, y1, on);
                end
            end
            MODE_FILL: begin
                if (bx > 0 && by > 0) begin
                    for (int r = (ay < 0 ? 0 : ay); r < (ay + by > FH ? FH : ay + by); r++)
                        for (int c = (ax < 0 ? 0 : ax); c < (ax + bx > FW ? FW : ax + bx); c++)
                            plot(c, r, on);
                end
            end
            MODE_INVERT: begin
                foreach (shadow_fb[i]) shadow_fb[i] = ~shadow_fb[i];
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic send_word(mode_t mode, int ax, int ay, int bx, int by, bit on);
        logic [11:0] fx, fy, gx, gy;
        int gap;
        fx = ax[11:0];
        fy = ay[11:0];
        gx = bx[11:0];
        gy = by[11:0];
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, on, gy, gx, fy, fx, mode};
        do @(posedge aclk); while (!s_tready);
        pixel_q.push_back(draw_cmd(mode, $signed(fx), $signed(fy), $signed(gx),
                                   $signed(gy), on));
        if ($urandom_range(99) < snd_idle_pct) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pixel_q.size() == 0) begin
                $error("unexpected word: pixel_value=%0d", m_tdata[0]);
                failed = 1'b1;
            end else begin
                automatic bit want = pixel_q.pop_front();
                if (m_tdata[0] !== want) begin
                    $error("pixel_value: expected %0d, got %0d", want, m_tdata[0]);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic int pick_coord(int span);
        if ($urandom_range(24) == 0) return $urandom_range(4095) - 2048;
        return $urandom_range(span + 16) - 8;
    endfunction

    function automatic int pick_size();
        if ($urandom_range(29) == 0) return $urandom_range(4095) - 2048;
        return $urandom_range(26) - 2;
    endfunction

    task automatic test_directed();
        send_word(MODE_READ, 0, 0, 0, 0, 1'b0);
        send_word(MODE_SET, 0, 0, 0, 0, 1'b1);
        send_word(MODE_SET, FW - 1, FH - 1, 0, 0, 1'b1);
        send_word(MODE_READ, 0, 0, 0, 0, 1'b0);
        send_word(MODE_READ, FW - 1, FH - 1, 0, 0, 1'b0);
        send_word(MODE_SET, -1, 5, 0, 0, 1'b1);
        send_word(MODE_SET, FW, 5, 0, 0, 1'b1);
        send_word(MODE_SET, 5, FH, 2047, -2048, 1'b1);
        send_word(MODE_READ, 2047, -2048, -1, -1, 1'b1);
        send_word(MODE_LINE, 100, 50, 10, 3, 1'b1);
        send_word(MODE_LINE, 20, 60, 22, 1, 1'b1);
        send_word(MODE_LINE, 7, 7, 7, 7, 1'b1);
        send_word(MODE_LINE, -2048, -2048, 2047, 2047, 1'b1);
        send_word(MODE_RECT, -5, -5, 20, 20, 1'b1);
        send_word(MODE_RECT, 30, 30, 0, 10, 1'b1);
        send_word(MODE_FILL, 30, 30, 10, -3, 1'b1);
        send_word(MODE_FILL, 120, 60, 20, 20, 1'b1);
        send_word(MODE_READ, 14, 14, 0, 0, 1'b0);
        send_word(MODE_FILL, -2048, -2048, 2047, 2047, 1'b0);
        send_word(MODE_CLEAR, 0, 0, 0, 0, 1'b1);
        send_word(MODE_SET, 3, 3, 0, 0, 1'b0);
        send_word(MODE_INVERT, 0, 0, 0, 0, 1'b0);
        send_word(MODE_READ, 3, 3, 0, 0, 1'b0);
        send_word(MODE_NONE, 3, 3, 0, 0, 1'b1);
        send_word(MODE_CLEAR, 0, 0, 0, 0, 1'b0);
    endtask

    task automatic test_random(int count);
        int sel;
        mode_t mode;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if      (sel < 35) mode = MODE_READ;
            else if (sel < 55) mode = MODE_SET;
            else if (sel < 70) mode = MODE_LINE;
            else if (sel < 78) mode = MODE_RECT;
            else if (sel < 88) mode = MODE_FILL;
            else if (sel < 92) mode = MODE_CLEAR;
            else if (sel < 96) mode = MODE_INVERT;
            else               mode = MODE_NONE;
            if (mode == MODE_RECT || mode == MODE_FILL)
                send_word(mode, pick_coord(FW), pick_coord(FH), pick_size(), pick_size(),
                          1'($urandom_range(1)));
            else
                send_word(mode, pick_coord(FW), pick_coord(FH), pick_coord(FW),
                          pick_coord(FH), 1'($urandom_range(1)));
        end
    endtask

    initial begin
        failed       = 1'b0;
        snd_idle_pct = 12;
        rcv_idle_pct = 62;
        foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(310);
        snd_idle_pct = 62;
        rcv_idle_pct = 12;
        test_random(310);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random(310);
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (!failed) $display("** mono_framebuffer_draw_engine: PASSED **");
        else $display("** mono_framebuffer_draw_engine: FAILED **");
        $finish;
    end

    initial begin
        #2_000_000_000;
        $display("** mono_framebuffer_draw_engine: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
design/mfde_pkg.sv
design/mfde_datapath.sv
design/mfde_ctrl.sv
design/mono_framebuffer_draw_engine.sv
bench/tb_top.sv
